/* design/v3a_pkg.sv */
// Shared constants, command codes, sideband types and the saturation helper
// for the three-component fixed-point vector ALU. No dependencies.
package v3a_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int SQRT_STEPS    = 32;

	localparam logic [3:0] CMD_ADD   = 4'd0;
	localparam logic [3:0] CMD_SUB   = 4'd1;
	localparam logic [3:0] CMD_SCALE = 4'd2;
	localparam logic [3:0] CMD_MUL   = 4'd3;
	localparam logic [3:0] CMD_DIVS  = 4'd4;
	localparam logic [3:0] CMD_DIVV  = 4'd5;
	localparam logic [3:0] CMD_DOT   = 4'd6;
	localparam logic [3:0] CMD_CROSS = 4'd7;
	localparam logic [3:0] CMD_LEN   = 4'd8;
	localparam logic [3:0] CMD_LENSQ = 4'd9;
	localparam logic [3:0] CMD_NORM  = 4'd10;

	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

	// Sideband that follows an item once the divider operands are formed.
	typedef struct packed {
		logic [3:0]       cmd;
		logic [2:0][31:0] r;
		logic [31:0]      s;
		logic             ov;
		logic [2:0]       dz;
		logic [2:0]       neg;
		logic [2:0]       asg;
		logic             vzero;
	} post_t;

	// Sideband through the square-root cells, still holding the magnitudes.
	typedef struct packed {
		post_t            base;
		logic [2:0][31:0] amag;
		logic [2:0][31:0] dmag;
	} pre_t;

	// Returns {overflow, clamped value}.
	function automatic logic [32:0] sat66(input logic signed [65:0] v);
		if (v > SAT_HI) begin
			return {1'b1, Q_MAX};
		end else if (v < SAT_LO) begin
			return {1'b1, Q_MIN};
		end
		return {1'b0, v[31:0]};
	endfunction

endpackage

/* design/v3a_front.sv */
// Front end: operand selection, six lane multipliers, then sums, shifts and
// saturation. Depends on v3a_pkg.
module v3a_front import v3a_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic [3:0]         command,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	input  logic signed [31:0] scalar_in,
	output pre_t               side_s2,
	output logic [63:0]        sq_s2
);

	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	logic signed [31:0] a [3];
	logic signed [31:0] b [3];
	logic signed [31:0] ma [3];
	logic signed [31:0] mb [3];
	logic signed [63:0] p_d [3];
	logic signed [63:0] q_d [3];

	logic [3:0]         cmd_s1;
	logic signed [31:0] a_s1 [3];
	logic signed [31:0] b_s1 [3];
	logic signed [31:0] c_s1;
	logic signed [63:0] p_s1 [3];
	logic signed [63:0] q_s1 [3];

	pre_t               pre_d;
	logic [63:0]        sq_d;
	logic signed [32:0] sum_add;
	logic signed [32:0] sum_sub;
	logic signed [63:0] pshift;
	logic signed [64:0] cdiff;
	logic signed [65:0] sum3;
	logic [32:0]        sat [3];
	logic [32:0]        sat_s;
	logic               d_neg;

	assign a = '{ax, ay, az};
	assign b = '{bx, by, bz};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ma[i] = a[i];
			unique case (command)
				CMD_SCALE: mb[i] = scalar_in;
				CMD_LEN, CMD_LENSQ, CMD_NORM: mb[i] = a[i];
				CMD_CROSS: begin
					ma[i] = a[NXT[i]];
					mb[i] = b[PRV[i]];
				end
				default: mb[i] = b[i];
			endcase
			p_d[i] = 64'(ma[i]) * 64'(mb[i]);
			q_d[i] = 64'(a[PRV[i]]) * 64'(b[NXT[i]]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= command;
			a_s1   <= a;
			b_s1   <= b;
			c_s1   <= scalar_in;
			p_s1   <= p_d;
			q_s1   <= q_d;
		end
	end

	always_comb begin
		pre_d = '0;
		pre_d.base.cmd = cmd_s1;
		sum3 = 66'(p_s1[0]) + 66'(p_s1[1]) + 66'(p_s1[2]);
		sq_d = sum3[63:0];
		sat_s = sat66(sum3 >>> FRAC_BITS);
		for (int i = 0; i < 3; i++) begin
			sum_add = 33'(a_s1[i]) + 33'(b_s1[i]);
			sum_sub = 33'(a_s1[i]) - 33'(b_s1[i]);
			pshift  = p_s1[i] >>> FRAC_BITS;
			cdiff   = 65'(p_s1[i]) - 65'(q_s1[i]);
			unique case (cmd_s1)
				CMD_ADD:          sat[i] = sat66(66'(sum_add));
				CMD_SUB:          sat[i] = sat66(66'(sum_sub));
				CMD_SCALE, CMD_MUL: sat[i] = sat66(66'(pshift));
				CMD_CROSS:        sat[i] = sat66(66'(cdiff >>> FRAC_BITS));
				default:          sat[i] = '0;
			endcase
			pre_d.base.r[i]   = sat[i][31:0];
			pre_d.base.asg[i] = a_s1[i][31];
			pre_d.amag[i]     = a_s1[i][31] ? 32'(-a_s1[i]) : a_s1[i];
			d_neg = 1'b0;
			unique case (cmd_s1)
				CMD_DIVS: begin
					d_neg = c_s1[31];
					pre_d.dmag[i] = c_s1[31] ? 32'(-c_s1) : c_s1;
					pre_d.base.dz[i] = (c_s1 == 32'sd0);
				end
				CMD_DIVV: begin
					d_neg = b_s1[i][31];
					pre_d.dmag[i] = b_s1[i][31] ? 32'(-b_s1[i]) : b_s1[i];
					pre_d.base.dz[i] = (b_s1[i] == 32'sd0);
				end
				default: begin
					pre_d.dmag[i] = '0;
					pre_d.base.dz[i] = 1'b0;
				end
			endcase
			pre_d.base.neg[i] = a_s1[i][31] ^ d_neg;
		end
		unique case (cmd_s1)
			CMD_ADD, CMD_SUB, CMD_SCALE, CMD_MUL, CMD_CROSS:
				pre_d.base.ov = sat[0][32] | sat[1][32] | sat[2][32];
			CMD_DOT, CMD_LENSQ: begin
				pre_d.base.s  = sat_s[31:0];
				pre_d.base.ov = sat_s[32];
			end
			default: pre_d.base.ov = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= pre_d;
			sq_s2   <= sq_d;
		end
	end

endmodule

/* design/v3a_sqrt_cell.sv */
// One step of the bitwise integer square root over a 64-bit radicand.
// Depends on v3a_pkg.
module v3a_sqrt_cell import v3a_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] n_i,
	input  logic [63:0] r_i,
	output logic [63:0] n_q,
	output logic [63:0] r_q
);

	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

	logic [63:0] trial;
	logic        take;

	assign trial = r_i + BIT;
	assign take  = (n_i >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			n_q <= take ? n_i - trial : n_i;
			r_q <= take ? (r_i >> 1) + BIT : r_i >> 1;
		end
	end

endmodule

/* design/v3a_div_cell.sv */
// One restoring division step for all three lanes: the quotient bit is
// shifted into the dividend register as its top bit leaves. Depends on v3a_pkg.
module v3a_div_cell import v3a_pkg::*; #(
	parameter int QW = 32 + FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          en,
	input  logic [31:0]   rem_i [3],
	input  logic [QW-1:0] num_i [3],
	input  logic [31:0]   den_i [3],
	output logic [31:0]   rem_q [3],
	output logic [QW-1:0] num_q [3],
	output logic [31:0]   den_q [3]
);

	logic [32:0] trial [3];
	logic [32:0] diff [3];
	logic        ge [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_i[i], num_i[i][QW-1]};
			diff[i]  = trial[i] - {1'b0, den_i[i]};
			ge[i]    = (trial[i] >= {1'b0, den_i[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= ge[i] ? diff[i][31:0] : trial[i][31:0];
				num_q[i] <= {num_i[i][QW-2:0], ge[i]};
				den_q[i] <= den_i[i];
			end
		end
	end

endmodule

/* design/vec3_fixed_point_alu.sv */
// Pipeline from an input transfer to the result (Q16.16 by default): two front
// stages, 32 square-root cells, one setup stage, 32 + FRAC_BITS division cells
// and the output register.
// Throughput: one item per cycle; the whole chain holds while a result waits.
// Reset: arst_n clears the valid bits only; the data path needs no reset.
module vec3_fixed_point_alu import v3a_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         command,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	input  logic signed [31:0] scalar_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] rx,
	output logic signed [31:0] ry,
	output logic signed [31:0] rz,
	output logic signed [31:0] scalar_out,
	output logic               overflowed,
	output logic               divided_by_zero
);

	localparam int QW = 32 + FRAC_BITS;

	logic adv;
	logic v_s1, v_s2, v_s3;
	logic v_sq [SQRT_STEPS];
	logic v_dv [QW];

	pre_t        side_s2;
	logic [63:0] sq_s2;
	pre_t        side_sq [SQRT_STEPS];
	logic [63:0] sq_n [SQRT_STEPS+1];
	logic [63:0] sq_r [SQRT_STEPS+1];

	post_t         post_d;
	post_t         post_s3;
	logic [QW-1:0] num_s3 [3];
	logic [31:0]   den_s3 [3];
	post_t         side_dv [QW];
	logic [31:0]   dv_rem [QW+1][3];
	logic [QW-1:0] dv_num [QW+1][3];
	logic [31:0]   dv_den [QW+1][3];

	logic [31:0] len;
	post_t       fin;
	logic [31:0] qv [3];
	logic        qov [3];
	logic [QW-1:0] qq;
	logic [2:0][31:0] r_o;
	logic [31:0] s_o;
	logic        ov_o;

	logic [31:0] rx_q, ry_q, rz_q, s_q;
	logic        ov_q, dz_q, out_valid_q;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < SQRT_STEPS; k++) v_sq[k] <= 1'b0;
			for (int k = 0; k < QW; k++) v_dv[k] <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_sq[0] <= v_s2;
			for (int k = 1; k < SQRT_STEPS; k++) v_sq[k] <= v_sq[k-1];
			v_s3 <= v_sq[SQRT_STEPS-1];
			v_dv[0] <= v_s3;
			for (int k = 1; k < QW; k++) v_dv[k] <= v_dv[k-1];
			out_valid_q <= v_dv[QW-1];
		end
	end

	v3a_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .en(adv), .command(command),
		.ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
		.scalar_in(scalar_in), .side_s2(side_s2), .sq_s2(sq_s2)
	);

	assign sq_n[0] = sq_s2;
	assign sq_r[0] = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		v3a_sqrt_cell #(.STEP(k)) u_cell (
			.clk(clk), .en(adv),
			.n_i(sq_n[k]), .r_i(sq_r[k]),
			.n_q(sq_n[k+1]), .r_q(sq_r[k+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sq[0] <= side_s2;
			for (int k = 1; k < SQRT_STEPS; k++) side_sq[k] <= side_sq[k-1];
		end
	end

	// The root of a sum of three squares always fits in 32 bits.
	assign len = sq_r[SQRT_STEPS][31:0];

	always_comb begin
		post_d = side_sq[SQRT_STEPS-1].base;
		if (post_d.cmd == CMD_LEN) begin
			post_d.s  = len[31] ? Q_MAX : len;
			post_d.ov = len[31];
		end
		post_d.vzero = (len == 32'd0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			post_s3 <= post_d;
			for (int i = 0; i < 3; i++) begin
				num_s3[i] <= {side_sq[SQRT_STEPS-1].amag[i], {FRAC_BITS{1'b0}}};
				den_s3[i] <= (side_sq[SQRT_STEPS-1].base.cmd == CMD_NORM) ?
					len : side_sq[SQRT_STEPS-1].dmag[i];
			end
		end
	end

	assign dv_rem[0] = '{32'd0, 32'd0, 32'd0};
	assign dv_num[0] = num_s3;
	assign dv_den[0] = den_s3;

	for (genvar j = 0; j < QW; j++) begin : g_div
		v3a_div_cell #(.QW(QW)) u_cell (
			.clk(clk), .en(adv),
			.rem_i(dv_rem[j]), .num_i(dv_num[j]), .den_i(dv_den[j]),
			.rem_q(dv_rem[j+1]), .num_q(dv_num[j+1]), .den_q(dv_den[j+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_dv[0] <= post_s3;
			for (int k = 1; k < QW; k++) side_dv[k] <= side_dv[k-1];
		end
	end

	assign fin = side_dv[QW-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qq = dv_num[QW][i];
			if (fin.dz[i]) begin
				qv[i]  = fin.asg[i] ? Q_MIN : Q_MAX;
				qov[i] = 1'b0;
			end else if (fin.neg[i]) begin
				qov[i] = (|qq[QW-1:32]) || (qq[31] && (|qq[30:0]));
				qv[i]  = qov[i] ? Q_MIN : 32'(-qq[31:0]);
			end else begin
				qov[i] = |qq[QW-1:31];
				qv[i]  = qov[i] ? Q_MAX : qq[31:0];
			end
		end
		r_o  = fin.r;
		s_o  = fin.s;
		ov_o = fin.ov;
		unique case (fin.cmd)
			CMD_DIVS, CMD_DIVV: begin
				r_o  = {qv[2], qv[1], qv[0]};
				ov_o = qov[0] | qov[1] | qov[2];
			end
			CMD_NORM: begin
				// A zero vector normalises to itself with no flag.
				if (fin.vzero) begin
					r_o  = '0;
					ov_o = 1'b0;
				end else begin
					r_o  = {qv[2], qv[1], qv[0]};
					ov_o = qov[0] | qov[1] | qov[2];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_q <= r_o[0];
			ry_q <= r_o[1];
			rz_q <= r_o[2];
			s_q  <= s_o;
			ov_q <= ov_o;
			dz_q <= |fin.dz;
		end
	end

	assign out_valid       = out_valid_q;
	assign rx              = rx_q;
	assign ry              = ry_q;
	assign rz              = rz_q;
	assign scalar_out      = s_q;
	assign overflowed      = ov_q;
	assign divided_by_zero = dz_q;

	// A zero divisor always leaves at least one saturated component.
	a_dz_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divided_by_zero |->
			(rx == Q_MAX || rx == Q_MIN || ry == Q_MAX || ry == Q_MIN ||
			 rz == Q_MAX || rz == Q_MIN))
		else $error("divide by zero without a saturated component");

	// Scalar results never come with a vector.
	a_scalar_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scalar_out != 32'd0 |-> rx == 32'd0 && ry == 32'd0 && rz == 32'd0)
		else $error("scalar result carries a non-zero vector");

	// While the output is held, the chain ahead of it must not move.
	a_chain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(v_dv[QW-1]) && $stable(v_s3))
		else $error("pipeline advanced during an output stall");

endmodule

/* dv/vec3_fixed_point_alu_tb.sv */
// Self-checking testbench for vec3_fixed_point_alu: directed edge cases and a random
// stream, with random idling on both channels, checked against an in-bench predictor.
// Depends on design/v3a_pkg.sv and design/vec3_fixed_point_alu.sv.
module vec3_fixed_point_alu_tb;
	import v3a_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam logic [3:0] CMD_SPARE_LOW = 4'd11;
	localparam logic [3:0] CMD_SPARE_TOP = 4'd15;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] s;
		logic        ov;
		logic        dz;
	} vres_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [3:0]         command;
	logic signed [31:0] ax, ay, az, bx, by, bz, scalar_in;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] rx, ry, rz, scalar_out;
	logic               overflowed;
	logic               divided_by_zero;

	vres_t pending_results[$];
	int    mismatch_count;
	int    cycle_count = 0;
	bit    quiet;

	vec3_fixed_point_alu u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .ax(ax), .ay(ay), .az(az),
		.bx(bx), .by(by), .bz(bz), .scalar_in(scalar_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.rx(rx), .ry(ry), .rz(rz), .scalar_out(scalar_out),
		.overflowed(overflowed), .divided_by_zero(divided_by_zero)
	);

	always #4 clk = ~clk;

	// Returns {saturated, clamped value}.
	function automatic logic [32:0] clamp_q(input logic signed [95:0] v);
		if (v > 96'sd2147483647) begin
			return {1'b1, Q_MAX};
		end else if (v < -96'sd2147483648) begin
			return {1'b1, Q_MIN};
		end
		return {1'b0, v[31:0]};
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		probe = 64'h4000_0000_0000_0000;
		while (probe > n) probe = probe >> 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n = n - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic vres_t predict_vec_op(input logic [3:0] cmd,
			input logic signed [31:0] a0, a1, a2, b0, b1, b2, c);
		logic signed [95:0] a[3];
		logic signed [95:0] b[3];
		logic signed [95:0] cv, sq, len, d;
		logic [32:0] r[3];
		logic [32:0] s;
		logic dz;
		vres_t res;
		a[0] = 96'(a0); a[1] = 96'(a1); a[2] = 96'(a2);
		b[0] = 96'(b0); b[1] = 96'(b1); b[2] = 96'(b2);
		cv = 96'(c);
		r[0] = '0; r[1] = '0; r[2] = '0;
		s = '0;
		dz = 1'b0;
		sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		len = {32'b0, int_sqrt(sq[63:0])};
		for (int i = 0; i < 3; i++) begin
			case (cmd)
				CMD_ADD:   r[i] = clamp_q(a[i] + b[i]);
				CMD_SUB:   r[i] = clamp_q(a[i] - b[i]);
				CMD_SCALE: r[i] = clamp_q((a[i] * cv) >>> FB);
				CMD_MUL:   r[i] = clamp_q((a[i] * b[i]) >>> FB);
				CMD_DIVS, CMD_DIVV: begin
					d = (cmd == CMD_DIVS) ? cv : b[i];
					if (d == 0) begin
						// A zero divisor saturates without counting as an overflow.
						dz = 1'b1;
						r[i] = {1'b0, (a[i] < 0) ? Q_MIN : Q_MAX};
					end else begin
						r[i] = clamp_q((a[i] <<< FB) / d);
					end
				end
				CMD_NORM: begin
					if (sq != 0) r[i] = clamp_q((a[i] <<< FB) / len);
				end
				default: ;
			endcase
		end
		case (cmd)
			CMD_DOT:   s = clamp_q((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FB);
			CMD_LEN:   s = clamp_q(len);
			CMD_LENSQ: s = clamp_q(sq >>> FB);
			CMD_CROSS: begin
				r[0] = clamp_q((a[1] * b[2] - a[2] * b[1]) >>> FB);
				r[1] = clamp_q((a[2] * b[0] - a[0] * b[2]) >>> FB);
				r[2] = clamp_q((a[0] * b[1] - a[1] * b[0]) >>> FB);
			end
			default: ;
		endcase
		res.x = r[0][31:0];
		res.y = r[1][31:0];
		res.z = r[2][31:0];
		res.s = s[31:0];
		res.ov = r[0][32] | r[1][32] | r[2][32] | s[32];
		res.dz = dz;
		return res;
	endfunction

	// Operand values biased towards the corners of the range.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return Q_MAX;
			2: return Q_MIN;
			3: return $urandom_range(0, 8) << FB;
			4: return -($urandom_range(1, 8) << FB);
			5: return $urandom_range(0, 255) - 128;
			6: return ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [3:0] cmd,
			input logic [31:0] a0, a1, a2, b0, b1, b2, c);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		ax <= a0; ay <= a1; az <= a2;
		bx <= b0; by <= b1; bz <= b2;
		scalar_in <= c;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_vec_op(cmd, a0, a1, a2, b0, b1, b2, c));
	endtask

	task automatic test_arith_edges();
		send_item(CMD_ADD, Q_MAX, Q_MIN, 32'd5, Q_MAX, Q_MIN, -32'sd5, 32'd0);
		send_item(CMD_SUB, Q_MIN, Q_MAX, 32'd0, 32'd1, -32'sd1, Q_MIN, 32'd0);
		send_item(CMD_SCALE, Q_MAX, Q_MIN, -32'sd3, 32'd0, 32'd0, 32'd0, Q_MIN);
		send_item(CMD_SCALE, 32'h0001_8000, -32'sd1, 32'd7, 32'd0, 32'd0, 32'd0, 32'h0000_8000);
		send_item(CMD_MUL, Q_MIN, -32'sd1, 32'h0002_0000, Q_MIN, 32'd1, 32'h0003_0000, 32'd0);
		send_item(CMD_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'd0);
		send_item(CMD_DOT, -32'sd1, 32'd1, 32'd3, 32'd1, 32'd1, -32'sd1, 32'd0);
		send_item(CMD_CROSS, Q_MIN, Q_MAX, 32'h0001_0000, Q_MAX, Q_MIN, -32'sd1, 32'd0);
		send_item(CMD_LEN, Q_MIN, Q_MIN, Q_MIN, 32'd0, 32'd0, 32'd0, 32'd0);
		send_item(CMD_LEN, 32'h0003_0000, 32'h0004_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_item(CMD_LENSQ, Q_MIN, Q_MAX, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
		send_item(CMD_SPARE_TOP, Q_MAX, Q_MIN, 32'd1, Q_MAX, Q_MIN, 32'd1, Q_MAX);
		send_item(CMD_SPARE_LOW, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7);
	endtask

	task automatic test_division_by_zero();
		send_item(CMD_DIVS, 32'd0, -32'sd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
		send_item(CMD_DIVS, Q_MIN, Q_MAX, 32'd3, 32'd0, 32'd0, 32'd0, -32'sd1);
		send_item(CMD_DIVV, 32'd0, Q_MIN, 32'h0001_0000, 32'd0, 32'd0, 32'h0003_0000, 32'd0);
		send_item(CMD_DIVV, Q_MAX, -32'sd7, 32'd9, 32'd1, 32'h0002_0000, -32'sd2, 32'd0);
	endtask

	task automatic test_normalize();
		send_item(CMD_NORM, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1, 32'd1);
		send_item(CMD_NORM, 32'h0003_0000, -32'sh0004_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_item(CMD_NORM, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_item(CMD_NORM, Q_MIN, Q_MIN, Q_MIN, 32'd0, 32'd0, 32'd0, 32'd0);
	endtask

	task automatic test_random_stream(input int count);
		logic [3:0] cmd;
		for (int n = 0; n < count; n++) begin
			cmd = ($urandom_range(0, 15) == 0) ?
				4'($urandom_range(CMD_SPARE_LOW, CMD_SPARE_TOP)) :
				4'($urandom_range(CMD_ADD, CMD_NORM));
			send_item(cmd, pick_operand(), pick_operand(), pick_operand(),
				pick_operand(), pick_operand(), pick_operand(), pick_operand());
		end
	endtask

	// Back-to-back transfers with both sides always ready.
	task automatic test_steady_stream(input int count);
		quiet = 1'b1;
		test_random_stream(count);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = '0;
		ax = '0; ay = '0; az = '0;
		bx = '0; by = '0; bz = '0;
		scalar_in = '0;
		mismatch_count = 0;
		quiet = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_arith_edges();
		test_division_by_zero();
		test_normalize();
		test_random_stream(1300);
		test_steady_stream(250);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("vec3_fixed_point_alu: match");
		end else begin
			$display("vec3_fixed_point_alu: mismatch");
		end
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		vres_t want;
		vres_t got;
		got = {rx, ry, rz, scalar_out, overflowed, divided_by_zero};
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("unexpected result transfer: %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("result differs: exp x=%h y=%h z=%h s=%h ov=%b dz=%b",
							want.x, want.y, want.z, want.s, want.ov, want.dz);
						$display("                got x=%h y=%h z=%h s=%h ov=%b dz=%b",
							got.x, got.y, got.z, got.s, got.ov, got.dz);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("vec3_fixed_point_alu: mismatch");
			$finish;
		end
	end

endmodule
